FILE: sv/acflw_pkg.sv
// ----------------------------------------------------------------------------
// acflw_pkg: shared types and constants of the associative write-back cache
// Holds the action and result codes, the queued item format and defaults.
// ----------------------------------------------------------------------------
package acflw_pkg;

  // Default geometry.
  localparam int unsigned NUM_LINES_DEF      = 16;
  localparam int unsigned WORDS_PER_LINE_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // Widest word offset within a line (lines hold at most sixteen words).
  localparam int unsigned OFF_MAX_W = 4;
  localparam int unsigned PID_SHIFT = 24;
  localparam logic [23:0] BLOCK_MASK = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_INVAL = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_WBACK  = 3'd2,
    KIND_REFILL = 3'd3,
    KIND_INVAL  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HIT,
    ST_WB_RD,
    ST_WB_OUT,
    ST_REQ,
    ST_FIN_WR,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_e;

  // One classified beat as it waits between front and back.
  typedef struct packed {
    action_e               action;
    logic [OFF_MAX_W-1:0]  offset;
    logic [31:0]           tag;
    logic [31:0]           wdata;
    logic [31:0]           fdata;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

endpackage

FILE: sv/assoc_cache_fifo_lru_writeback.sv
// ----------------------------------------------------------------------------
// assoc_cache_fifo_lru_writeback: fully associative write-back word cache
// Front splits addresses, a two-entry queue decouples it from the engine.
// ----------------------------------------------------------------------------
// A beat passes the front stage and the queue; a write hit or invalidate
// result is registered when the engine pops it, a read hit after the word
// store read. The engine takes a new beat only while idle; a miss reads and
// emits each victim word when the victim is dirty, then one request beat.
// Each refill word is a queued beat; the last one ends in the pending access.
// Reset clears all lines, ages, counters and the pending miss at once; word
// contents are unknown until refilled.
module assoc_cache_fifo_lru_writeback #(
  parameter int unsigned NUM_LINES      = acflw_pkg::NUM_LINES_DEF,
  parameter int unsigned WORDS_PER_LINE = acflw_pkg::WORDS_PER_LINE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [27:0] byte_address_i,
  input  logic [7:0]  process_id_i,
  input  logic [31:0] write_word_i,
  input  logic [31:0] fill_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [27:0] mem_address_o,
  output logic [31:0] mem_data_o,
  output logic [31:0] read_word_o,
  output logic        was_hit_o,
  output logic        last_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o
);
  import acflw_pkg::*;

  logic   q_full, q_push, q_pop, q_empty;
  item_t  push_item, head_item;
  logic [ITEM_W-1:0] head_bits;

  // The policy register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign head_item   = item_t'(head_bits);

  acflw_front #(
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .byte_address_i (byte_address_i),
    .process_id_i   (process_id_i),
    .write_word_i   (write_word_i),
    .fill_word_i    (fill_word_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  acflw_fifo #(
    .DEPTH (QUEUE_DEPTH_DEF),
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (head_bits),
    .empty_o (q_empty)
  );

  acflw_back #(
    .NUM_LINES      (NUM_LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .q_empty_i     (q_empty),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .kind_o        (kind_o),
    .mem_address_o (mem_address_o),
    .mem_data_o    (mem_data_o),
    .read_word_o   (read_word_o),
    .was_hit_o     (was_hit_o),
    .last_o        (last_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

FILE: sv/acflw_fifo.sv
// ----------------------------------------------------------------------------
// acflw_fifo: short queue between front and back
// Registered entries with read and write pointers; no fall-through.
// ----------------------------------------------------------------------------
module acflw_fifo #(
  parameter int unsigned DEPTH = acflw_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = acflw_pkg::ITEM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import acflw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/acflw_front.sv
// ----------------------------------------------------------------------------
// acflw_front: accepts input beats and splits the address
// Two stages: a reciprocal multiply, then a remainder correction that yields
// the word offset and the process and block tag.
// ----------------------------------------------------------------------------
module acflw_front #(
  parameter int unsigned WORDS_PER_LINE = acflw_pkg::WORDS_PER_LINE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          action_i,
  input  logic [27:0]         byte_address_i,
  input  logic [7:0]          process_id_i,
  input  logic [31:0]         write_word_i,
  input  logic [31:0]         fill_word_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output acflw_pkg::item_t    q_item_o
);
  import acflw_pkg::*;

  // floor(2^32 / W): the estimate is at most one below the true quotient.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / WORDS_PER_LINE);

  logic        s1_valid_q;
  action_e     s1_act_q;
  logic [25:0] s1_x_q, s1_q0_q;
  logic [7:0]  s1_pid_q;
  logic [31:0] s1_wdata_q, s1_fdata_q;

  logic [58:0] prod;
  logic        take;
  logic [29:0] qw, rem_full;
  logic [5:0]  rem;
  logic [25:0] quot;

  assign in_stall_o = s1_valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign q_push_o   = s1_valid_q && !q_full_i;
  assign prod       = 59'(byte_address_i[27:2]) * 59'(RECIP);

  // First stage: capture the beat and the quotient estimate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_act_q   <= action_e'(action_i);
      s1_x_q     <= byte_address_i[27:2];
      s1_q0_q    <= prod[57:32];
      s1_pid_q   <= process_id_i;
      s1_wdata_q <= write_word_i;
      s1_fdata_q <= fill_word_i;
    end
  end

  // Second stage: correct the estimate by at most one step.
  always_comb begin
    qw       = 30'(s1_q0_q) * 30'(WORDS_PER_LINE);
    rem_full = 30'(s1_x_q) - qw;
    rem      = rem_full[5:0];
    quot     = s1_q0_q;
    if (rem >= 6'(WORDS_PER_LINE)) begin
      rem  = rem - 6'(WORDS_PER_LINE);
      quot = s1_q0_q + 26'd1;
    end
    q_item_o.action = s1_act_q;
    q_item_o.offset = rem[OFF_MAX_W-1:0];
    q_item_o.tag    = {s1_pid_q, quot[23:0] & BLOCK_MASK};
    q_item_o.wdata  = s1_wdata_q;
    q_item_o.fdata  = s1_fdata_q;
  end

endmodule

FILE: sv/acflw_back.sv
// ----------------------------------------------------------------------------
// acflw_back: cache engine
// Tag match, replacement, write-back and refill sequencing, the word store
// and the result register.
// ----------------------------------------------------------------------------
module acflw_back #(
  parameter int unsigned NUM_LINES      = acflw_pkg::NUM_LINES_DEF,
  parameter int unsigned WORDS_PER_LINE = acflw_pkg::WORDS_PER_LINE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              q_empty_i,
  input  acflw_pkg::item_t  q_item_i,
  output logic              q_pop_o,
  output logic [2:0]        kind_o,
  output logic [27:0]       mem_address_o,
  output logic [31:0]       mem_data_o,
  output logic [31:0]       read_word_o,
  output logic              was_hit_o,
  output logic              last_o,
  output logic [31:0]       hit_total_o,
  output logic [31:0]       miss_total_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);
  import acflw_pkg::*;

  localparam int unsigned LINE_W  = $clog2(NUM_LINES);
  localparam int unsigned MDEPTH  = NUM_LINES * WORDS_PER_LINE;
  localparam int unsigned MADDR_W = $clog2(MDEPTH);
  localparam int unsigned CNT_W   = $clog2(WORDS_PER_LINE + 1);
  localparam int unsigned OFF_W   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;

  // Word store address of a line and word.
  function automatic logic [MADDR_W-1:0] waddr_of(logic [LINE_W-1:0] line,
                                                  logic [4:0] off);
    logic [31:0] a;
    a = 32'(line) * 32'(WORDS_PER_LINE) + 32'(off);
    return a[MADDR_W-1:0];
  endfunction

  // Byte address of the first word of a line from its tag.
  function automatic logic [27:0] base_of(logic [31:0] tag);
    logic [33:0] p;
    p = 34'(tag[23:0]) * 34'(4 * WORDS_PER_LINE);
    return p[27:0];
  endfunction

  // Line state.
  logic [31:0]       tags_q  [NUM_LINES];
  logic [LINE_W-1:0] rank_q  [NUM_LINES];
  logic [NUM_LINES-1:0] valid_q, dirty_q;
  logic [31:0]       words_q [MDEPTH];
  logic [31:0]       rdata_q;

  // Pending miss.
  logic              pend_q, pend_write_q;
  logic [OFF_W-1:0]  pend_off_q;
  logic [31:0]       pend_tag_q, pend_data_q;
  logic [LINE_W-1:0] pend_line_q;
  logic [CNT_W-1:0]  fill_cnt_q;

  // Write-back victim.
  logic [LINE_W-1:0] vic_q;
  logic [27:0]       vbase_q;
  logic [CNT_W-1:0]  wb_cnt_q;

  logic              policy_q;
  logic [31:0]       hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;
  state_e            state_q, state_d;

  // Result register.
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [27:0]       out_addr_q;
  logic [31:0]       out_data_q, out_rd_q, out_hit_tot_q, out_miss_tot_q;
  logic              out_hit_q, out_last_q;

  // Lookup.
  logic [NUM_LINES-1:0] hit_vec;
  logic              hit_any, inv_found, old_found;
  logic [LINE_W-1:0] hit_idx, inv_idx, old_idx, vic;
  logic              slot_free, head_ok, access, is_last_fill;

  // Actions.
  logic              do_clear, cfg_chg, clr, fill_inc, do_load, do_miss;
  logic              hit_inc, touch, hit_wr, fin_wr;
  logic              mem_we, mem_re;
  logic [MADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;
  logic              emit;
  kind_e             e_kind;
  logic [27:0]       e_addr;
  logic [31:0]       e_data, e_rd;
  logic              e_hit, e_last;

  assign slot_free    = !out_valid_q || !out_stall_i;
  assign head_ok      = !q_empty_i && slot_free;
  assign access       = (q_item_i.action == ACT_READ) || (q_item_i.action == ACT_WRITE);
  assign is_last_fill = (fill_cnt_q == CNT_W'(WORDS_PER_LINE - 1));
  assign cfg_chg      = cfg_we_i && (cfg_data_i != policy_q);
  assign clr          = do_clear || cfg_chg;

  // Parallel tag match, first free line and oldest line.
  always_comb begin
    hit_any   = 1'b0;
    inv_found = 1'b0;
    old_found = 1'b0;
    hit_idx   = '0;
    inv_idx   = '0;
    old_idx   = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      hit_vec[i] = valid_q[i] && (tags_q[i] == q_item_i.tag);
      if (hit_vec[i] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = LINE_W'(i);
      end
      if (!valid_q[i] && !inv_found) begin
        inv_found = 1'b1;
        inv_idx   = LINE_W'(i);
      end
      if (rank_q[i] == LINE_W'(NUM_LINES - 1) && !old_found) begin
        old_found = 1'b1;
        old_idx   = LINE_W'(i);
      end
    end
    vic = inv_found ? inv_idx : old_idx;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_ok) begin
          if (q_item_i.action == ACT_FILL) begin
            if (pend_q && is_last_fill) begin
              state_d = pend_write_q ? ST_FIN_WR : ST_FIN_RD;
            end
          end else if (access && !pend_q) begin
            if (hit_any) begin
              if (q_item_i.action == ACT_READ) begin
                state_d = ST_RD_HIT;
              end
            end else begin
              state_d = (valid_q[vic] && dirty_q[vic]) ? ST_WB_RD : ST_REQ;
            end
          end
        end
      end
      ST_RD_HIT:  if (slot_free) state_d = ST_IDLE;
      ST_WB_RD:   state_d = ST_WB_OUT;
      ST_WB_OUT: begin
        if (slot_free) begin
          state_d = (wb_cnt_q == CNT_W'(WORDS_PER_LINE - 1)) ? ST_REQ : ST_WB_RD;
        end
      end
      ST_REQ:     if (slot_free) state_d = ST_IDLE;
      ST_FIN_WR:  if (slot_free) state_d = ST_IDLE;
      ST_FIN_RD:  state_d = ST_FIN_OUT;
      ST_FIN_OUT: if (slot_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Actions of each state.
  always_comb begin
    q_pop_o   = 1'b0;
    do_clear  = 1'b0;
    fill_inc  = 1'b0;
    do_load   = 1'b0;
    do_miss   = 1'b0;
    hit_inc   = 1'b0;
    touch     = 1'b0;
    hit_wr    = 1'b0;
    fin_wr    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = q_item_i.wdata;
    emit      = 1'b0;
    e_kind    = KIND_READ;
    e_addr    = '0;
    e_data    = '0;
    e_rd      = '0;
    e_hit     = 1'b0;
    e_last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_ok) begin
          q_pop_o = 1'b1;
          case (q_item_i.action)
            ACT_INVAL: begin
              do_clear = 1'b1;
              emit     = 1'b1;
              e_kind   = KIND_INVAL;
              e_last   = 1'b1;
            end
            ACT_FILL: begin
              if (pend_q) begin
                mem_we    = 1'b1;
                mem_waddr = waddr_of(pend_line_q, 5'(fill_cnt_q));
                mem_wdata = q_item_i.fdata;
                do_load   = is_last_fill;
                fill_inc  = !is_last_fill;
              end
            end
            default: begin
              if (!pend_q) begin
                if (hit_any) begin
                  hit_inc = 1'b1;
                  touch   = policy_q;
                  if (q_item_i.action == ACT_WRITE) begin
                    hit_wr    = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = waddr_of(hit_idx, 5'(q_item_i.offset[OFF_W-1:0]));
                    emit      = 1'b1;
                    e_kind    = KIND_WRITE;
                    e_hit     = 1'b1;
                    e_last    = 1'b1;
                  end else begin
                    mem_re    = 1'b1;
                    mem_raddr = waddr_of(hit_idx, 5'(q_item_i.offset[OFF_W-1:0]));
                  end
                end else begin
                  do_miss = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ST_RD_HIT: begin
        emit   = slot_free;
        e_kind = KIND_READ;
        e_rd   = rdata_q;
        e_hit  = 1'b1;
        e_last = 1'b1;
      end
      ST_WB_RD: begin
        mem_re    = 1'b1;
        mem_raddr = waddr_of(vic_q, 5'(wb_cnt_q));
      end
      ST_WB_OUT: begin
        emit   = slot_free;
        e_kind = KIND_WBACK;
        e_addr = vbase_q + 28'({wb_cnt_q, 2'b00});
        e_data = rdata_q;
      end
      ST_REQ: begin
        emit   = slot_free;
        e_kind = KIND_REFILL;
        e_addr = base_of(pend_tag_q);
        e_last = 1'b1;
      end
      ST_FIN_WR: begin
        if (slot_free) begin
          fin_wr    = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = waddr_of(pend_line_q, 5'(pend_off_q));
          mem_wdata = pend_data_q;
          emit      = 1'b1;
          e_kind    = KIND_WRITE;
          e_last    = 1'b1;
        end
      end
      ST_FIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = waddr_of(pend_line_q, 5'(pend_off_q));
      end
      ST_FIN_OUT: begin
        emit   = slot_free;
        e_kind = KIND_READ;
        e_rd   = rdata_q;
        e_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign hit_cnt_d  = hit_cnt_q + 32'(hit_inc);
  assign miss_cnt_d = miss_cnt_q + 32'(do_miss);

  // Control state: line flags, ages, pending miss, counters and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      pend_q      <= 1'b0;
      fill_cnt_q  <= '0;
      wb_cnt_q    <= '0;
      policy_q    <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (cfg_chg) begin
        policy_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_WB_OUT && slot_free) begin
        wb_cnt_q <= wb_cnt_q + 1'b1;
      end
      if (clr) begin
        valid_q    <= '0;
        dirty_q    <= '0;
        pend_q     <= 1'b0;
        fill_cnt_q <= '0;
        for (int i = 0; i < NUM_LINES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        if (fill_inc) begin
          fill_cnt_q <= fill_cnt_q + 1'b1;
        end
        // A loaded line becomes the youngest and every other valid line ages.
        if (do_load) begin
          valid_q[pend_line_q] <= 1'b1;
          dirty_q[pend_line_q] <= 1'b0;
          pend_q               <= 1'b0;
          fill_cnt_q           <= '0;
          for (int i = 0; i < NUM_LINES; i++) begin
            if (LINE_W'(i) == pend_line_q) begin
              rank_q[i] <= '0;
            end else if (valid_q[i]) begin
              rank_q[i] <= rank_q[i] + 1'b1;
            end
          end
        end
        if (fin_wr) begin
          dirty_q[pend_line_q] <= 1'b1;
        end
        // Under LRU a hit makes the line youngest and ages the younger ones.
        if (touch) begin
          for (int i = 0; i < NUM_LINES; i++) begin
            if (LINE_W'(i) == hit_idx) begin
              rank_q[i] <= '0;
            end else if (valid_q[i] && rank_q[i] < rank_q[hit_idx]) begin
              rank_q[i] <= rank_q[i] + 1'b1;
            end
          end
        end
        if (hit_wr) begin
          dirty_q[hit_idx] <= 1'b1;
        end
        if (do_miss) begin
          valid_q[vic] <= 1'b0;
          dirty_q[vic] <= 1'b0;
          pend_q       <= 1'b1;
          fill_cnt_q   <= '0;
          wb_cnt_q     <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      tags_q[pend_line_q] <= pend_tag_q;
    end
    if (do_miss) begin
      vic_q        <= vic;
      vbase_q      <= base_of(tags_q[vic]);
      pend_write_q <= (q_item_i.action == ACT_WRITE);
      pend_off_q   <= q_item_i.offset[OFF_W-1:0];
      pend_tag_q   <= q_item_i.tag;
      pend_data_q  <= q_item_i.wdata;
      pend_line_q  <= vic;
    end
    if (emit) begin
      out_kind_q     <= e_kind;
      out_addr_q     <= e_addr;
      out_data_q     <= e_data;
      out_rd_q       <= e_rd;
      out_hit_q      <= e_hit;
      out_last_q     <= e_last;
      out_hit_tot_q  <= hit_cnt_d;
      out_miss_tot_q <= miss_cnt_d;
    end
  end

  // Word store with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      words_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= words_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign mem_address_o = out_addr_q;
  assign mem_data_o    = out_data_q;
  assign read_word_o   = out_rd_q;
  assign was_hit_o     = out_hit_q;
  assign last_o        = out_last_q;
  assign hit_total_o   = out_hit_tot_q;
  assign miss_total_o  = out_miss_tot_q;

  // A tag is held by at most one valid line.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec))
    else $error("several lines match one tag");

  // The refill count never reaches a full line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q < CNT_W'(WORDS_PER_LINE))
    else $error("refill count overran the line");

  // A clear leaves no valid line and no pending miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (valid_q == '0) && !pend_q)
    else $error("clear left state behind");

  // The queue is only drained while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE))
    else $error("beat taken while busy");

  // A miss starts only when no miss is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_miss |-> !pend_q)
    else $error("second miss while one is pending");

endmodule
